// ----- hdl/cma_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants of the centered moving average unit
// Field widths, item structs, ring and divider request/response structs.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int RADIUS_BITS  = 6;
  localparam int LEN_BITS     = RADIUS_BITS + 1;
  localparam int RING_AW      = 7;
  localparam int SUM_BITS     = SAMPLE_BITS + RING_AW;
  localparam int AVG_BITS     = 17;
  localparam int COUNT_BITS   = 8;
  localparam int MAX_RADIUS   = 63;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);
  localparam logic [AVG_BITS-1:0]    NO_AVERAGE   = '1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [RING_AW-1:0]     ring_addr_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } sample_item_t;

  typedef struct packed {
    logic signed [AVG_BITS-1:0] average;
    logic                       last_result;
  } result_item_t;

  typedef struct packed {
    logic       wr_en;
    ring_addr_t wr_addr;
    sample_t    wr_data;
    logic       rd_en;
    ring_addr_t rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic start;
    sum_t dividend;
    len_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    sum_t quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/cma_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cma_ring: sample ring store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cma_ring (
  input  wire logic                clk,
  input  wire cma_pkg::ring_req_t  req,
  output      cma_pkg::sample_t    rd_data
);

  localparam int DEPTH = 2 ** cma_pkg::RING_AW;

  cma_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cma_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cma_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with quotient.
// ----------------------------------------------------------------------------
module cma_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cma_pkg::div_req_t req,
  output      cma_pkg::div_rsp_t rsp
);

  localparam int STEPS    = cma_pkg::SUM_BITS;
  localparam int CNT_BITS = $clog2(STEPS);
  localparam int LB       = cma_pkg::LEN_BITS;

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [LB-1:0]       rem;
  logic [LB-1:0]       dsr;
  cma_pkg::sum_t       quo;

  logic [LB:0]   trial;
  logic [LB:0]   diff;
  logic          ge;
  logic [LB-1:0] rem_next;
  cma_pkg::sum_t quo_next;

  always_comb begin
    trial    = {rem, quo[STEPS-1]};
    diff     = trial - {1'b0, dsr};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? diff[LB-1:0] : trial[LB-1:0];
    quo_next = {quo[STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_BITS'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ----- hdl/centered_moving_average_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// centered_moving_average_unit: centered moving average over a sample stream
// Running window sum kept against a ring store; mean by an iterative divider.
// ----------------------------------------------------------------------------
//
// Channel        Dir   Handshake                  Payload
// sample_item    in    sample_valid/sample_ready  sample, last_sample
// result_item    out   result_valid/result_ready  average, last_result
// radius         in    radius_we (no stall)       radius_wdata
//
// Sequence: an item is taken only in idle. Accept cycle issues the ring write of
// the new sample and the ring read of the leaving one; the next cycle updates
// the sum. A full window then runs the divider, one quotient bit per cycle, to
// done and the output register; a window that does not fit skips the divider,
// one with no result also the emit, and the tail gives each trailing -1.
// Reset: synchronous, active high; radius returns to 1, the sum, count and
// write pointer to zero. The ring is not cleared: read data is only used after
// it was written in the current stream.
// Stalls: one output register; the sequencer waits while it holds an item not
// yet taken, and the next sample may be accepted while the last result waits.
//
module centered_moving_average_unit #(
  parameter int MAX_RADIUS = cma_pkg::MAX_RADIUS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output      logic                               sample_ready,
  input  wire cma_pkg::sample_item_t              sample_item,
  output      logic                               result_valid,
  input  wire logic                               result_ready,
  output      cma_pkg::result_item_t              result_item,
  input  wire logic                               radius_we,
  input  wire logic [cma_pkg::RADIUS_BITS-1:0]    radius_wdata
);

  localparam int RB = cma_pkg::RADIUS_BITS;
  localparam int CB = cma_pkg::COUNT_BITS;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_SUM  = 3'd1;  // ring data back, update sum
  localparam logic [2:0] S_DIV  = 3'd2;  // divider running
  localparam logic [2:0] S_EMIT = 3'd3;  // main result to output register
  localparam logic [2:0] S_TAIL = 3'd4;  // trailing -1 results, restart

  logic [2:0] state;
  logic [2:0] state_next;

  // stream state
  logic [RB-1:0]       radius;
  cma_pkg::sum_t       running_sum;
  logic [CB-1:0]       sample_count;
  cma_pkg::ring_addr_t write_pointer;

  // per item latches
  cma_pkg::sample_t            cur_sample;
  logic                        last_q;
  logic                        leave_q;   // a sample leaves the window
  logic                        avg_q;     // window fits, divide
  logic                        emit_q;    // a main result is due
  logic [RB-1:0]               pend_cnt;
  logic [cma_pkg::AVG_BITS-1:0] avg_val;

  // window length and compares on the count before this sample
  cma_pkg::len_t win_len;
  logic          accept;
  logic          slot_free;
  logic          load;
  cma_pkg::result_item_t load_item;
  cma_pkg::sum_t sum_next;

  cma_pkg::ring_req_t ring_req;
  cma_pkg::sample_t   ring_rd;
  cma_pkg::div_req_t  div_req;
  cma_pkg::div_rsp_t  div_rsp;

  assign win_len      = {radius, 1'b1};
  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign slot_free    = !result_valid || result_ready;

  // ring: new sample at the write pointer, leaving one len entries behind
  always_comb begin
    ring_req.wr_en   = accept;
    ring_req.wr_addr = write_pointer;
    ring_req.wr_data = sample_item.sample;
    ring_req.rd_en   = accept;
    ring_req.rd_addr = write_pointer - win_len;
  end

  cma_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd)
  );

  // add the new sample, drop the leaving one
  assign sum_next = running_sum + cma_pkg::sum_t'(cur_sample)
                  - (leave_q ? cma_pkg::sum_t'(ring_rd) : '0);

  always_comb begin
    div_req.start    = (state == S_SUM) && avg_q;
    div_req.dividend = sum_next;
    div_req.divisor  = win_len;
  end

  cma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // output register loads
  always_comb begin
    load      = 1'b0;
    load_item = '{average: avg_val, last_result: last_q && (radius == '0)};
    unique case (state)
      S_EMIT: begin
        load = slot_free;
      end
      S_TAIL: begin
        load      = slot_free && (pend_cnt != '0);
        load_item = '{average: cma_pkg::NO_AVERAGE,
                      last_result: (pend_cnt == RB'(1))};
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SUM;
      S_SUM: begin
        priority if (avg_q)  state_next = S_DIV;
        else if (emit_q)     state_next = S_EMIT;
        else                 state_next = S_TAIL;
      end
      S_DIV:  if (div_rsp.done) state_next = S_EMIT;
      S_EMIT: if (slot_free) state_next = S_TAIL;
      S_TAIL: if (pend_cnt == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      radius        <= cma_pkg::RADIUS_RESET;
      running_sum   <= '0;
      sample_count  <= '0;
      write_pointer <= '0;
      pend_cnt      <= '0;
      last_q        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // radius only between streams; clamp to the supported maximum
      if (radius_we && (sample_count == '0)) begin
        radius <= (radius_wdata > RB'(MAX_RADIUS)) ? RB'(MAX_RADIUS) : radius_wdata;
      end

      if (accept) begin
        write_pointer <= write_pointer + 1'b1;
        if (sample_count != cma_pkg::COUNT_MAX) begin
          sample_count <= sample_count + 1'b1;
        end
        last_q <= sample_item.last_sample;
        // indices still pending at end of stream: min(count + 1, radius)
        if (!sample_item.last_sample) begin
          pend_cnt <= '0;
        end else if (sample_count < CB'(radius)) begin
          pend_cnt <= sample_count[RB-1:0] + 1'b1;
        end else begin
          pend_cnt <= radius;
        end
      end

      if (state == S_SUM) begin
        running_sum <= sum_next;
      end

      if (load && (state == S_TAIL)) begin
        pend_cnt <= pend_cnt - 1'b1;
      end

      // end of stream: back to a fresh window
      if ((state == S_TAIL) && (pend_cnt == '0) && last_q) begin
        running_sum   <= '0;
        sample_count  <= '0;
        write_pointer <= '0;
        last_q        <= 1'b0;
      end

      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= sample_item.sample;
      leave_q    <= sample_count >= CB'(win_len);
      avg_q      <= sample_count >= CB'({radius, 1'b0});
      emit_q     <= sample_count >= CB'(radius);
    end
    if (state == S_SUM) begin
      avg_val <= cma_pkg::NO_AVERAGE;
    end
    if (div_rsp.done) begin
      avg_val <= div_rsp.quotient[cma_pkg::AVG_BITS-1:0];
    end
    if (load) begin
      result_item <= load_item;
    end
  end

`ifndef SYNTH
  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider done outside S_DIV");

  // trailing results exist only for a last sample
  a_pend_needs_last: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt != '0) |-> last_q)
    else $error("pending results without last sample");

  // radius holds while an item is in work
  a_radius_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(radius))
    else $error("radius changed mid item");

  // an accepted item always goes to the sum update next
  a_accept_to_sum: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SUM))
    else $error("accept not followed by sum update");
`endif

endmodule
`default_nettype wire
